// File: hw/rtl/iaf_pkg.sv
// ----------------------------------------------------------------------------
// iaf_pkg
// Types, constants and helper functions for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package iaf_pkg;

   localparam int VAL_W   = 32;                 // operand width
   localparam int DIG_N   = 10;                 // decimal digits of a 32-bit value
   localparam int DIG_W   = 4 * DIG_N;          // packed BCD / nibble vector
   localparam int DBITS   = 4;                  // operand bits shifted in per stage
   localparam int DSTAGES = VAL_W / DBITS;      // shift-add-3 stages
   localparam int QDEPTH  = 16;                 // converted-request queue depth
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);
   localparam int CHR_W   = 8;
   localparam int CNT_W   = 4;                  // character count / index width

   typedef enum logic [1:0] {
      FMT_SDEC = 2'd0,
      FMT_UDEC = 2'd1,
      FMT_LHEX = 2'd2,
      FMT_UHEX = 2'd3
   } fmt_type;

   localparam logic [CHR_W-1:0] CHAR_MINUS = 8'h2D;

   // index 0 holds '0'
   localparam logic [15:0][CHR_W-1:0] LOWER_SET = "fedcba9876543210";
   localparam logic [15:0][CHR_W-1:0] UPPER_SET = "FEDCBA9876543210";

   // one converted request waiting for the serialiser
   typedef struct packed {
      logic [DIG_W-1:0] dig;     // digit nibbles, least significant at bit 0
      logic [CNT_W-1:0] ndig;    // significant digits, at least 1
      logic             neg;     // leading minus sign
      logic             upper;   // uppercase hex letters
   } conv_type;

   // one shift-add-3 step: correct every BCD digit, then shift in a bit
   function automatic logic [DIG_W-1:0] dabble_step(input logic [DIG_W-1:0] bcd,
                                                     input logic            b);
      logic [DIG_W-1:0] t;
      t = bcd;
      for (int j = 0; j < DIG_N; j++) begin
         if (t[4*j +: 4] >= 4'd5) begin
            t[4*j +: 4] = t[4*j +: 4] + 4'd3;
         end
      end
      return {t[DIG_W-2:0], b};
   endfunction

   // position of the highest non-zero nibble plus one; zero gives 1
   function automatic logic [CNT_W-1:0] count_digits(input logic [DIG_W-1:0] dig);
      logic [CNT_W-1:0] n;
      n = CNT_W'(1);
      for (int j = 1; j < DIG_N; j++) begin
         if (dig[4*j +: 4] != 4'd0) begin
            n = CNT_W'(j + 1);
         end
      end
      return n;
   endfunction

   function automatic logic [CHR_W-1:0] digit_char(input logic [3:0] d,
                                                    input logic       upper);
      logic [CHR_W-1:0] c;
      c = upper ? UPPER_SET[d] : LOWER_SET[d];
      return c;
   endfunction

endpackage

// File: hw/rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Converts a 32-bit value to signed/unsigned decimal or hex ASCII text and
// sends it one character per cycle, most significant character first.
// ----------------------------------------------------------------------------
//  channel   ports                                    handshake
//  --------  ---------------------------------------  -------------------------
//  request   req_cmd[1:0], req_value[31:0]            start high, busy low
//  response  rsp_char_code[7:0], rsp_last_char,        rsp_strobe, one cycle,
//            rsp_char_total[3:0]                      no back-pressure
//
//  A request yields 1 to 11 characters, all sent through the single
//  character output; new requests are accepted while earlier text is still
//  being sent.
//  Conversion runs in an 11-stage pipeline (input, sign, 8 shift-add-3 stages,
//  queue write) feeding a 16-entry queue; busy rises when 16 requests are in
//  the pipeline or queue. Synchronous reset empties pipeline, queue and output.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core
   import iaf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_cmd,
   input  logic [VAL_W-1:0] req_value,
   output logic             rsp_strobe,
   output logic [CHR_W-1:0] rsp_char_code,
   output logic             rsp_last_char,
   output logic [CNT_W-1:0] rsp_char_total
);

   logic accept;
   logic pop;

   // ---------------- input stage ----------------
   logic             in_vld_ff;
   logic [1:0]       in_cmd_ff;
   logic [VAL_W-1:0] in_value_ff;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= accept;
      end
      in_cmd_ff   <= req_cmd;
      in_value_ff <= req_value;
   end

   // ---------------- conversion pipeline ----------------
   // index 0: magnitude and sign; 1..DSTAGES: shift-add-3 stages
   logic             p_vld_ff [DSTAGES+1];
   logic [1:0]       p_cmd_ff [DSTAGES+1];
   logic [VAL_W-1:0] p_val_ff [DSTAGES+1];
   logic [DIG_W-1:0] p_bcd_ff [DSTAGES+1];
   logic             p_neg_ff [DSTAGES+1];

   logic             sgn_neg_in;
   logic [VAL_W-1:0] sgn_mag_in;

   always_comb begin
      sgn_neg_in = (in_cmd_ff == FMT_SDEC) && in_value_ff[VAL_W-1];
      sgn_mag_in = sgn_neg_in ? (~in_value_ff + VAL_W'(1)) : in_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff[0] <= 1'b0;
      end else begin
         p_vld_ff[0] <= in_vld_ff;
      end
      p_cmd_ff[0] <= in_cmd_ff;
      p_val_ff[0] <= sgn_mag_in;
      p_bcd_ff[0] <= '0;
      p_neg_ff[0] <= sgn_neg_in;
   end

   for (genvar i = 0; i < DSTAGES; i++) begin : g_dab
      logic [DIG_W-1:0] bcd_in;

      always_comb begin
         bcd_in = p_bcd_ff[i];
         for (int j = 0; j < DBITS; j++) begin
            bcd_in = dabble_step(bcd_in, p_val_ff[i][VAL_W-1-i*DBITS-j]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            p_vld_ff[i+1] <= 1'b0;
         end else begin
            p_vld_ff[i+1] <= p_vld_ff[i];
         end
         p_cmd_ff[i+1] <= p_cmd_ff[i];
         p_val_ff[i+1] <= p_val_ff[i];
         p_bcd_ff[i+1] <= bcd_in;
         p_neg_ff[i+1] <= p_neg_ff[i];
      end
   end

   // ---------------- queue ----------------
   conv_type          q_wr;
   conv_type          q_mem_ff [QDEPTH];
   logic [QPTR_W-1:0] q_wptr_ff, q_rptr_ff;
   logic [QCNT_W-1:0] q_cnt_ff;
   logic [QCNT_W-1:0] occ_ff, occ_in;
   logic              q_push;
   logic              is_hex;

   always_comb begin
      is_hex       = (p_cmd_ff[DSTAGES] == FMT_LHEX) || (p_cmd_ff[DSTAGES] == FMT_UHEX);
      q_wr.dig     = is_hex ? {{(DIG_W-VAL_W){1'b0}}, p_val_ff[DSTAGES]}
                            : p_bcd_ff[DSTAGES];
      q_wr.ndig    = count_digits(q_wr.dig);
      q_wr.neg     = p_neg_ff[DSTAGES];
      q_wr.upper   = (p_cmd_ff[DSTAGES] == FMT_UHEX);
      q_push       = p_vld_ff[DSTAGES];
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem_ff[q_wptr_ff] <= q_wr;
      end
   end

   // occupancy covers the pipeline and the queue, so the queue never overflows
   always_comb begin
      occ_in = occ_ff;
      if (accept && !pop) begin
         occ_in = occ_ff + QCNT_W'(1);
      end else if (!accept && pop) begin
         occ_in = occ_ff - QCNT_W'(1);
      end
   end

   assign busy = (occ_ff == QCNT_W'(QDEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wptr_ff <= '0;
         q_rptr_ff <= '0;
         q_cnt_ff  <= '0;
         occ_ff    <= '0;
      end else begin
         occ_ff <= occ_in;
         if (q_push) begin
            q_wptr_ff <= q_wptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            q_rptr_ff <= q_rptr_ff + QPTR_W'(1);
         end
         if (q_push && !pop) begin
            q_cnt_ff <= q_cnt_ff + QCNT_W'(1);
         end else if (!q_push && pop) begin
            q_cnt_ff <= q_cnt_ff - QCNT_W'(1);
         end
      end
   end

   // ---------------- serialiser ----------------
   conv_type         ser_ff;
   logic             ser_act_ff;
   logic [CNT_W-1:0] ser_pos_ff;
   logic [CNT_W-1:0] ser_total;
   logic [CNT_W-1:0] ser_idx;
   logic             ser_last;
   logic [CHR_W-1:0] ser_char;

   logic             rsp_strobe_ff;
   logic [CHR_W-1:0] rsp_char_code_ff;
   logic             rsp_last_char_ff;
   logic [CNT_W-1:0] rsp_char_total_ff;

   always_comb begin
      ser_total = ser_ff.ndig + CNT_W'(ser_ff.neg);
      ser_last  = ser_act_ff && (ser_pos_ff == ser_total - CNT_W'(1));
      ser_idx   = ser_ff.ndig - CNT_W'(1) - (ser_pos_ff - CNT_W'(ser_ff.neg));
      if (ser_ff.neg && (ser_pos_ff == '0)) begin
         ser_char = CHAR_MINUS;
      end else begin
         ser_char = digit_char(ser_ff.dig[4*ser_idx +: 4], ser_ff.upper);
      end
      pop = (q_cnt_ff != '0) && (!ser_act_ff || ser_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_act_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ser_act_ff;
         if (pop) begin
            ser_act_ff <= 1'b1;
         end else if (ser_last) begin
            ser_act_ff <= 1'b0;
         end
      end
      if (pop) begin
         ser_ff     <= q_mem_ff[q_rptr_ff];
         ser_pos_ff <= '0;
      end else begin
         ser_pos_ff <= ser_pos_ff + CNT_W'(1);
      end
      rsp_char_code_ff  <= ser_char;
      rsp_last_char_ff  <= ser_last;
      rsp_char_total_ff <= ser_last ? ser_total : '0;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_char_code  = rsp_char_code_ff;
   assign rsp_last_char  = rsp_last_char_ff;
   assign rsp_char_total = rsp_char_total_ff;

endmodule

// File: hw/rtl/integer_to_ascii_formatter_checker.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_props
// Port-level checks on the formatter's busy flag and response stream, bound to the core.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_props
   import iaf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             rsp_strobe,
   input logic [CHR_W-1:0] rsp_char_code,
   input logic             rsp_last_char,
   input logic [CNT_W-1:0] rsp_char_total
);

   // reset leaves nothing in flight
   a_reset_idle : assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("response or busy after reset");

   a_total_only_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_char) |-> (rsp_char_total == '0))
      else $error("character count on a non-final character");

   a_total_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_char) |->
         ((rsp_char_total != '0) && (rsp_char_total <= CNT_W'(11))))
      else $error("character count out of range");

   // a minus sign only opens a text and never ends it
   a_minus_first : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_char_code == CHAR_MINUS) && !$past(reset)) |->
         (!rsp_last_char && (!$past(rsp_strobe) || $past(rsp_last_char))))
      else $error("minus sign out of place");

endmodule

bind integer_to_ascii_formatter_core integer_to_ascii_formatter_props u_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_char_code  (rsp_char_code),
   .rsp_last_char  (rsp_last_char),
   .rsp_char_total (rsp_char_total)
);
